>>> rtl/pjq_pkg.sv
// pjq_pkg: request and response transaction types, slot type, cell control
// and operation/status codes for the priority job queue. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pjq_pkg;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_INSERTED   = 2'd0;
  localparam logic [1:0] STATUS_FULL       = 2'd1;
  localparam logic [1:0] STATUS_REMOVED    = 2'd2;
  localparam logic [1:0] STATUS_EMPTY      = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [31:0]        job_id;
    logic signed [15:0] job_priority;
  } job_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        out_job_id;
    logic signed [15:0] out_priority;
    logic [2:0]         occupancy;
  } job_out_t;

  typedef struct packed {
    logic [31:0]        job_id;
    logic signed [15:0] job_priority;
  } slot_t;

  typedef struct packed {
    logic do_insert;
    logic do_remove;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/pjq_cell.sv
// pjq_cell: one queue slot plus one stage of the running-maximum chain.
// Depends on pjq_pkg (slot_t, cell_ctrl_t).
`timescale 1ns / 1ps
`default_nettype none

module pjq_cell #(
  parameter int DEPTH = 4,
  parameter int POS   = 0
) (
  input  wire                           clk,
  input  wire pjq_pkg::cell_ctrl_t      ctrl,
  input  wire [$clog2(DEPTH+1)-1:0]     count,
  input  wire [$clog2(DEPTH)-1:0]       win_pos,
  input  wire pjq_pkg::slot_t           ins_slot,
  input  wire pjq_pkg::slot_t           right_slot,
  input  wire                           best_in_found,
  input  wire pjq_pkg::slot_t           best_in_slot,
  input  wire [$clog2(DEPTH)-1:0]       best_in_pos,
  output pjq_pkg::slot_t                slot,
  output logic                          best_out_found,
  output pjq_pkg::slot_t                best_out_slot,
  output logic [$clog2(DEPTH)-1:0]      best_out_pos
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] MY_POS  = PW'(POS);
  localparam logic [CW-1:0] MY_CPOS = CW'(POS);

  logic occupied;
  logic take_own;

  assign occupied = MY_CPOS < count;
  // strict compare: an equal priority further back never displaces the older one
  assign take_own = occupied &&
                    (!best_in_found ||
                     ($signed(slot.job_priority) > $signed(best_in_slot.job_priority)));

  always_ff @(posedge clk) begin
    if (ctrl.do_insert && (MY_CPOS == count)) begin
      slot <= ins_slot;
    end else if (ctrl.do_remove && (MY_POS >= win_pos)) begin
      slot <= right_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (take_own) begin
      best_out_found <= 1'b1;
      best_out_slot  <= slot;
      best_out_pos   <= MY_POS;
    end else begin
      best_out_found <= best_in_found;
      best_out_slot  <= best_in_slot;
      best_out_pos   <= best_in_pos;
    end
  end

endmodule

`default_nettype wire

>>> rtl/priority_job_queue_core.sv
// Priority job queue: insert appends in arrival order; remove takes the highest
// priority (oldest on a tie). Insert (also when full) and empty remove: result
// strobe in the cycle after start, and busy stays low. Remove: busy through
// the SCAN and TAKE states while the running maximum walks the cell chain one
// cell per cycle; the result strobe follows TAKE. rst (sync, high) empties the
// queue; results cannot be stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module priority_job_queue_core #(
  parameter int DEPTH = 4
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  output logic                    busy,
  input  wire pjq_pkg::job_in_t   req,
  output logic                    done,
  output pjq_pkg::job_out_t       rsp
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_TAKE = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [PW-1:0] scan_cnt;

  logic                accept;
  pjq_pkg::cell_ctrl_t ctrl;
  pjq_pkg::slot_t      ins_slot;

  // slot chain: entry DEPTH is the empty filler shifted into the last cell
  pjq_pkg::slot_t slots     [DEPTH+1];
  // running-maximum chain: entry 0 feeds the front cell, entry DEPTH is the winner
  logic           best_found[DEPTH+1];
  pjq_pkg::slot_t best_slot [DEPTH+1];
  logic [PW-1:0]  best_pos  [DEPTH+1];

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign ins_slot.job_id       = req.job_id;
  assign ins_slot.job_priority = req.job_priority;

  // insert writes the tail cell on the accept edge; remove closes the gap in TAKE
  assign ctrl.do_insert = accept && (req.kind == pjq_pkg::KIND_INSERT) &&
                          (count != CW'(DEPTH));
  assign ctrl.do_remove = (state == ST_TAKE);

  assign slots[DEPTH]  = '0;
  assign best_found[0] = 1'b0;
  assign best_slot[0]  = '0;
  assign best_pos[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pjq_cell #(
      .DEPTH (DEPTH),
      .POS   (i)
    ) u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .count          (count),
      .win_pos        (best_pos[DEPTH]),
      .ins_slot       (ins_slot),
      .right_slot     (slots[i+1]),
      .best_in_found  (best_found[i]),
      .best_in_slot   (best_slot[i]),
      .best_in_pos    (best_pos[i]),
      .slot           (slots[i]),
      .best_out_found (best_found[i+1]),
      .best_out_slot  (best_slot[i+1]),
      .best_out_pos   (best_pos[i+1])
    );
  end

  // Control: the chain result settles only after the running maximum has passed
  // every cell, since each cell registers its stage; SCAN waits for it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      scan_cnt <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.kind == pjq_pkg::KIND_INSERT) begin
              done <= 1'b1;
              if (count != CW'(DEPTH)) begin
                count <= count + CW'(1);
              end
            end else if (count == '0) begin
              done <= 1'b1;
            end else begin
              state    <= ST_SCAN;
              scan_cnt <= '0;
            end
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + PW'(1);
          if (scan_cnt == PW'(DEPTH - 1)) begin
            state <= ST_TAKE;
          end
        end
        ST_TAKE: begin
          done  <= 1'b1;
          count <= count - CW'(1);
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Response payload: no reset needed, qualified by done.
  always_ff @(posedge clk) begin
    if (state == ST_TAKE) begin
      rsp.status       <= pjq_pkg::STATUS_REMOVED;
      rsp.out_job_id   <= best_slot[DEPTH].job_id;
      rsp.out_priority <= best_slot[DEPTH].job_priority;
      rsp.occupancy    <= 3'(count - CW'(1));
    end else if (accept) begin
      rsp.out_job_id   <= '0;
      rsp.out_priority <= '0;
      if (req.kind == pjq_pkg::KIND_INSERT) begin
        if (count != CW'(DEPTH)) begin
          rsp.status    <= pjq_pkg::STATUS_INSERTED;
          rsp.occupancy <= 3'(count + CW'(1));
        end else begin
          rsp.status    <= pjq_pkg::STATUS_FULL;
          rsp.occupancy <= 3'(count);
        end
      end else begin
        rsp.status    <= pjq_pkg::STATUS_EMPTY;
        rsp.occupancy <= 3'(count);
      end
    end
  end

  // occupancy never runs past the number of cells
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  // a removal only reaches the take step with something held, and the chain found it
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAKE) |-> ((count != '0) && best_found[DEPTH]))
    else $error("take step with empty queue or no winner");

  // an insert transaction answers on the very next cycle
  a_insert_latency: assert property (@(posedge clk) disable iff (rst)
    (accept && (req.kind == pjq_pkg::KIND_INSERT)) |=> done)
    else $error("insert transaction not answered in one cycle");

  // a completed removal leaves one job fewer
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAKE) |=> (count == $past(count) - CW'(1)))
    else $error("removal did not decrement count");

endmodule

`default_nettype wire
